// File: rtl/cppg_pkg.sv
package cppg_pkg;

  // Sine table geometry
  localparam int TABLE_BITS = 12;
  localparam int QUARTER    = 1 << (TABLE_BITS - 2);
  localparam int SAMPLE_W   = 16;

  // Q2.30 angle constants for the table build
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // APB address width: six 32-bit registers at 4-byte spacing
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_RESET  = 2'd1,
    OP_PAUSE  = 2'd2,
    OP_RESUME = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_PHASE_RATE  = 3'd3,
    REG_START_PHASE = 3'd4,
    REG_CLOCKWISE   = 3'd5
  } reg_e;

  // Quarter-wave table, entries 0..QUARTER inclusive, Q1.15
  typedef logic [QUARTER:0][SAMPLE_W-1:0] qtab_t;

  // Integer Taylor series in Q2.30, evaluated at elaboration
  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] s;
    for (int k = 0; k <= QUARTER; k++) begin
      x  = (64'(k) * HALF_PI_Q30) >> (TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      d  = ((x2 * t) >> 30) / 64'd156;
      t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      d  = ((x2 * t) >> 30) / 64'd110;
      t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      d  = ((x2 * t) >> 30) / 64'd72;
      t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      d  = ((x2 * t) >> 30) / 64'd42;
      t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      d  = ((x2 * t) >> 30) / 64'd20;
      t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      d  = ((x2 * t) >> 30) / 64'd6;
      t  = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      s  = (x * t) >> 30;
      s  = (s + (64'd1 << 14)) >> 15;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      tab[k] = s[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

// File: rtl/circular_path_position_generator_top.sv
// Circular path position generator: one result word per input word.
// Sequence: a running time update passes S_MULA and S_PHS, then S_RDS, S_MULX,
// S_ADDX and S_ADDY; other words start at S_RDS. S_ADDY waits on a stalled output.
// No new word is taken until the result is loaded. A shared 33x33 multiplier forms
// the phase advance and both coordinate products, sine ROM read registered.
// Reset: asynchronous, active low; registers to reset values, paused, output empty.
module circular_path_position_generator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cppg_pkg::ADDR_W-1:0]   paddr,
  input  logic [cppg_pkg::DATA_W-1:0]   pwdata,
  output logic [cppg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [31:0]                   time_stamp_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic                          running_o
);
  import cppg_pkg::*;

  localparam int TAB_AW = TABLE_BITS - 1;  // addresses 0..QUARTER

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULA,
    S_PHS,
    S_RDS,
    S_MULX,
    S_ADDX,
    S_ADDY
  } state_e;

  state_e state_q;

  // configuration registers
  logic signed [31:0] origin_x_q;
  logic signed [31:0] origin_y_q;
  logic [30:0]        radius_q;
  logic [31:0]        phase_rate_q;
  logic [31:0]        start_phase_q;
  logic               clockwise_q;

  // motion state and datapath
  logic [31:0]         phase_q;
  logic [31:0]         last_time_q;
  logic                run_flag_q;
  logic [31:0]         elapsed_q;
  logic signed [15:0]  val_q;
  logic signed [47:0]  prod_q;
  logic signed [31:0]  px_q;

  // output register
  logic                out_valid_q;
  logic signed [31:0]  pos_x_q;
  logic signed [31:0]  pos_y_q;
  logic                running_q;

  logic               in_accept;
  logic               cfg_write;
  logic [2:0]         reg_sel;
  logic               out_free;
  logic               adv_needed;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_write   = psel && penable && pwrite;
  assign reg_sel     = paddr[ADDR_W-1:2];
  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv_needed  = (op_e'(operation_i) == OP_UPDATE) && run_flag_q;
  assign pready      = 1'b1;

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_ORIGIN_X:    prdata = origin_x_q;
      REG_ORIGIN_Y:    prdata = origin_y_q;
      REG_RADIUS:      prdata = {1'b0, radius_q};
      REG_PHASE_RATE:  prdata = phase_rate_q;
      REG_START_PHASE: prdata = start_phase_q;
      REG_CLOCKWISE:   prdata = {31'd0, clockwise_q};
      default:         prdata = '0;
    endcase
  end

  // sine ROM lookup: sine index in S_RDS, cosine (quarter turn on) later
  logic [TABLE_BITS-1:0] idx_base;
  logic [TABLE_BITS-1:0] idx_sel;
  logic [1:0]            quad;
  logic [TAB_AW-1:0]     k_ext;
  logic [TAB_AW-1:0]     tab_addr;
  logic [15:0]           tab_val;
  logic signed [15:0]    sine_val;

  assign idx_base = phase_q[31 -: TABLE_BITS];
  assign idx_sel  = (state_q == S_RDS) ? idx_base
                                       : idx_base + TABLE_BITS'(QUARTER);
  assign quad     = idx_sel[TABLE_BITS-1 -: 2];
  assign k_ext    = {1'b0, idx_sel[TABLE_BITS-3:0]};
  assign tab_addr = quad[0] ? (TAB_AW'(QUARTER) - k_ext) : k_ext;
  assign tab_val  = QTAB[tab_addr];
  assign sine_val = quad[1] ? -$signed(tab_val) : $signed(tab_val);

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_full;

  always_comb begin
    if (state_q == S_MULA) begin
      mul_a = $signed({1'b0, elapsed_q});
      mul_b = $signed({1'b0, phase_rate_q});
    end else begin
      mul_a = $signed({2'b00, radius_q});
      mul_b = $signed({{17{val_q[15]}}, val_q});
    end
  end
  assign mul_full = mul_a * mul_b;

  // center plus floor(product / 2^15), saturated to 32 bits
  logic signed [32:0] scaled;
  logic signed [31:0] center_sel;
  logic signed [33:0] coord_sum;
  logic signed [31:0] coord_sat;

  assign scaled     = prod_q[47:15];
  assign center_sel = (state_q == S_ADDX) ? origin_x_q : origin_y_q;
  assign coord_sum  = 34'(center_sel) + 34'(scaled);

  always_comb begin
    if (coord_sum[33:31] == 3'b000 || coord_sum[33:31] == 3'b111) begin
      coord_sat = coord_sum[31:0];
    end else if (coord_sum[33]) begin
      coord_sat = 32'sh8000_0000;
    end else begin
      coord_sat = 32'sh7FFF_FFFF;
    end
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      radius_q      <= 31'd65536;
      phase_rate_q  <= '0;
      start_phase_q <= '0;
      clockwise_q   <= 1'b1;
      phase_q       <= '0;
      last_time_q   <= '0;
      run_flag_q    <= 1'b0;
      elapsed_q     <= '0;
      val_q         <= '0;
      prod_q        <= '0;
      px_q          <= '0;
      out_valid_q   <= 1'b0;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      running_q     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_sel)
          REG_ORIGIN_X:    origin_x_q    <= pwdata;
          REG_ORIGIN_Y:    origin_y_q    <= pwdata;
          REG_RADIUS:      radius_q      <= pwdata[30:0];
          REG_PHASE_RATE:  phase_rate_q  <= pwdata;
          REG_START_PHASE: start_phase_q <= pwdata;
          REG_CLOCKWISE:   clockwise_q   <= pwdata[0];
          default: ;
        endcase
      end

      // S_ADDY refills the output itself whenever it is free
      if (out_valid_q && !out_stall_i && state_q != S_ADDY) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            elapsed_q <= time_stamp_i - last_time_q;
            unique case (op_e'(operation_i))
              OP_UPDATE: last_time_q <= time_stamp_i;
              OP_RESET: begin
                run_flag_q <= 1'b0;
                phase_q    <= start_phase_q;
              end
              OP_PAUSE:  run_flag_q <= 1'b0;
              OP_RESUME: run_flag_q <= 1'b1;
            endcase
            state_q <= adv_needed ? S_MULA : S_RDS;
          end
        end
        S_MULA: begin
          prod_q  <= mul_full[47:0];
          state_q <= S_PHS;
        end
        S_PHS: begin
          phase_q <= clockwise_q ? phase_q + prod_q[31:0] : phase_q - prod_q[31:0];
          state_q <= S_RDS;
        end
        S_RDS: begin
          val_q   <= sine_val;
          state_q <= S_MULX;
        end
        S_MULX: begin
          prod_q  <= mul_full[47:0];
          val_q   <= sine_val;
          state_q <= S_ADDX;
        end
        S_ADDX: begin
          px_q    <= coord_sat;
          prod_q  <= mul_full[47:0];
          state_q <= S_ADDY;
        end
        S_ADDY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pos_x_q     <= px_q;
            pos_y_q     <= coord_sat;
            running_q   <= run_flag_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign running_o   = running_q;

endmodule

// File: rtl/cppg_checker.sv
module cppg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  operation_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [31:0]          pos_x_o,
  input logic signed [31:0]          pos_y_o,
  input logic                        running_o
);
  import cppg_pkg::*;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // an accepted word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> in_stall_o)
    else $error("block ready right after accepting a word");

  // with an empty output, a result never shows in the cycle right after acceptance
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // control words with an empty output give a result carrying the run flag they set
  a_ctrl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !out_valid_o && (operation_i != OP_UPDATE) |-> ##5
      (out_valid_o && (running_o == ($past(operation_i, 5) == OP_RESUME))))
    else $error("control word result missing or wrong run flag");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o)
      && $stable(running_o))
    else $error("stalled result word changed");

endmodule

bind circular_path_position_generator_top cppg_checker u_cppg_checker (.*);
